// ===== hdl/skgr_pkg.sv =====
// Shared types and constants for the stream k-group reverser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package skgr_pkg;

  // Payload and register widths
  localparam int DATA_W      = 32;
  localparam int GS_W        = 5;
  localparam int CMP_W       = 8;   // common width for count vs. group size compare
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int MAX_GROUP_DEF = 16;

  // Register map (word index)
  localparam logic [0:0] REG_GROUP_SIZE = 1'b0;

  // Group size after reset
  localparam logic [GS_W-1:0] GROUP_SIZE_RST = 5'd1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } skgr_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic load;     // move next buffered element into the output register
  } skgr_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic emit_now;   // accepted element closes a run
    logic out_free;   // output register can take a new element
    logic last_item;  // current read position is the last of the run
  } skgr_status_t;

endpackage

// ===== hdl/stream_k_group_reverser.sv =====
// Top level of the stream k-group reverser: group size register, controller and datapath.
// Depends on skgr_pkg, skgr_ctrl and skgr_dp.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  in      | sink      | in_valid/in_stall | in_value, in_end_of_sequence
//  out     | source    | out_valid/stall   | out_value, out_run_last, out_sequence_last
//  config  | APB slave | psel/penable      | group_size at paddr 0
//
// An element that closes no run is only buffered. An element that closes a run of n
// results moves the controller to its emit state: the buffer has one read port, so one
// result is loaded into the output register per cycle while the output is free, and
// no input is taken while the run drains.
// Reset is synchronous and clears control state only; the buffer needs no clearing.
// A stalled output holds its result and delays the remaining results of the run.
`timescale 1ns / 1ps

module stream_k_group_reverser #(
  parameter int MAX_GROUP = skgr_pkg::MAX_GROUP_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [skgr_pkg::DATA_W-1:0]    in_value,
  input  logic                                  in_end_of_sequence,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [skgr_pkg::DATA_W-1:0]    out_value,
  output logic                                  out_run_last,
  output logic                                  out_sequence_last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [skgr_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [skgr_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [skgr_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);
  import skgr_pkg::*;

  logic [GS_W-1:0] group_size_r;
  logic            reg_hit;
  skgr_cmd_t       cmd;
  skgr_status_t    status;

  // Register decode: word index from the byte address
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_GROUP_SIZE);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= GROUP_SIZE_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      group_size_r <= pwdata[GS_W-1:0];
    end
  end

  assign prdata = reg_hit ? APB_DATA_W'(group_size_r) : '0;

  skgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  skgr_dp #(
    .MAX_GROUP (MAX_GROUP)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .group_size         (group_size_r),
    .in_value           (in_value),
    .in_end_of_sequence (in_end_of_sequence),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_value          (out_value),
    .out_run_last       (out_run_last),
    .out_sequence_last  (out_sequence_last)
  );

endmodule

// ===== hdl/skgr_ctrl.sv =====
// Sequencing state machine of the k-group reverser: accept phase and emit phase.
// Depends on skgr_pkg.
`timescale 1ns / 1ps

module skgr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  skgr_pkg::skgr_status_t status,
  output skgr_pkg::skgr_cmd_t    cmd
);
  import skgr_pkg::*;

  skgr_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    in_stall   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && status.emit_now) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.load = status.out_free;
        if (status.out_free && status.last_item) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/skgr_dp.sv =====
// Datapath of the k-group reverser: group buffer, fill count, run read-out, output register.
// Depends on skgr_pkg; driven by skgr_ctrl.
`timescale 1ns / 1ps

module skgr_dp #(
  parameter int MAX_GROUP = skgr_pkg::MAX_GROUP_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  skgr_pkg::skgr_cmd_t         cmd,
  output skgr_pkg::skgr_status_t      status,
  input  logic [skgr_pkg::GS_W-1:0]   group_size,
  input  logic signed [skgr_pkg::DATA_W-1:0] in_value,
  input  logic                       in_end_of_sequence,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [skgr_pkg::DATA_W-1:0] out_value,
  output logic                       out_run_last,
  output logic                       out_sequence_last
);
  import skgr_pkg::*;

  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  logic [DATA_W-1:0] buf_r [MAX_GROUP];

  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] n_r;
  logic [CW-1:0] pos_r;
  logic          rev_r;
  logic          eos_r;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r;
  logic              out_run_last_r;
  logic              out_seq_last_r;

  logic [CW-1:0] wr_idx;
  logic [CW-1:0] cnt;
  logic          reverse;
  logic [CW-1:0] rd_idx;
  logic          last_item;

  // Write position; clamp keeps it inside the buffer
  assign wr_idx = (fill_r >= CW'(MAX_GROUP)) ? CW'(MAX_GROUP - 1) : fill_r;
  assign cnt    = wr_idx + CW'(1);

  // Group complete: size zero acts as one, oversize acts as MAX_GROUP
  assign reverse = (group_size == '0) || (cnt == CW'(MAX_GROUP)) ||
                   (CMP_W'(cnt) >= CMP_W'(group_size));

  assign fill_nxt = (reverse || in_end_of_sequence) ? '0 : cnt;

  // Read position of the current element of the run
  assign rd_idx    = rev_r ? (n_r - CW'(1) - pos_r) : pos_r;
  assign last_item = ((pos_r + CW'(1)) == n_r);

  assign status.emit_now  = reverse || in_end_of_sequence;
  assign status.out_free  = !out_valid_r || !out_stall;
  assign status.last_item = last_item;

  // Group buffer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      buf_r[wr_idx[AW-1:0]] <= in_value;
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.accept) begin
      fill_r <= fill_nxt;
    end
  end

  // Run descriptor, taken with every accepted element; the closing element's stays for read-out
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      n_r   <= cnt;
      rev_r <= reverse;
      eos_r <= in_end_of_sequence;
      pos_r <= '0;
    end else if (cmd.load) begin
      pos_r <= pos_r + CW'(1);
    end
  end

  // Output register
  assign out_valid_nxt = cmd.load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_value_r    <= buf_r[rd_idx[AW-1:0]];
      out_run_last_r <= last_item;
      out_seq_last_r <= last_item && eos_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value         = out_value_r;
  assign out_run_last      = out_run_last_r;
  assign out_sequence_last = out_seq_last_r;

endmodule

// ===== hdl/skgr_checker.sv =====
// Port-level checks for the stream k-group reverser, bound to the top level.
// Depends on skgr_pkg and stream_k_group_reverser.
`timescale 1ns / 1ps

module skgr_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [skgr_pkg::DATA_W-1:0]  out_value,
  input logic                                out_run_last,
  input logic                                out_sequence_last,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [skgr_pkg::APB_ADDR_W-1:0]     paddr,
  input logic [skgr_pkg::APB_DATA_W-1:0]     pwdata,
  input logic [skgr_pkg::APB_DATA_W-1:0]     prdata
);
  import skgr_pkg::*;

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) &&
      $stable(out_run_last) && $stable(out_sequence_last))
    else $error("stalled result changed");

  // End of sequence always closes a run
  a_seq_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sequence_last |-> out_run_last)
    else $error("sequence end without run end");

  // Group size reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && !paddr[2] |=>
      paddr[2] || (prdata[GS_W-1:0] == $past(pwdata[GS_W-1:0])))
    else $error("group size readback mismatch");

endmodule

bind stream_k_group_reverser skgr_checker u_skgr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_value         (out_value),
  .out_run_last      (out_run_last),
  .out_sequence_last (out_sequence_last),
  .psel              (psel),
  .penable           (penable),
  .pwrite            (pwrite),
  .paddr             (paddr),
  .pwdata            (pwdata),
  .prdata            (prdata)
);

// ===== verif/group_order_checker.sv =====
// Checker for the stream k-group reverser: tracks the group size register and input
// transfers, predicts each output transfer and compares it field by field.
// Depends on skgr_pkg.
`timescale 1ns / 1ps

module group_order_checker #(
  parameter int MAX_GROUP = skgr_pkg::MAX_GROUP_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [skgr_pkg::DATA_W-1:0] in_value,
  input  logic                               in_end_of_sequence,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [skgr_pkg::DATA_W-1:0] out_value,
  input  logic                               out_run_last,
  input  logic                               out_sequence_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [skgr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [skgr_pkg::APB_DATA_W-1:0]    pwdata,
  output int                                 mismatches,
  output int                                 pending
);
  import skgr_pkg::*;

  localparam logic [APB_ADDR_W-1:0] GROUP_SIZE_ADDR = APB_ADDR_W'(4 * int'(REG_GROUP_SIZE));

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     run_last;
    logic                     seq_last;
  } result_t;

  result_t                  expected_results[$];
  logic signed [DATA_W-1:0] held[MAX_GROUP];
  int                       held_count;
  logic [GS_W-1:0]          group_size;

  // Zero acts as one, anything above the buffer depth as the full depth
  function automatic int reversal_span(input logic [GS_W-1:0] gs);
    if (gs == '0) return 1;
    if (int'(gs) > MAX_GROUP) return MAX_GROUP;
    return int'(gs);
  endfunction

  // Buffer one element; queue the run it closes, if any
  task automatic take_element(input logic signed [DATA_W-1:0] value, input logic eos);
    int      k;
    int      n;
    bit      backward;
    result_t r;
    k = reversal_span(group_size);
    if (held_count >= MAX_GROUP) held_count = MAX_GROUP - 1;
    held[held_count] = value;
    held_count++;
    if (held_count < k && !eos) return;
    // a full group (or more, after k was lowered) reverses; a short tail keeps its order
    backward = (held_count >= k);
    n = held_count;
    for (int i = 0; i < n; i++) begin
      r.value    = held[backward ? n - 1 - i : i];
      r.run_last = (i == n - 1);
      r.seq_last = (i == n - 1) && eos;
      expected_results.push_back(r);
    end
    held_count = 0;
  endtask

  task automatic report(input string field, input logic signed [DATA_W-1:0] want,
                        input logic signed [DATA_W-1:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected output transfer, expected none, actual value %0d",
               $time, out_value);
      return;
    end
    want = expected_results.pop_front();
    if (out_value !== want.value) report("out_value", want.value, out_value);
    if (out_run_last !== want.run_last) report("out_run_last", want.run_last, out_run_last);
    if (out_sequence_last !== want.seq_last)
      report("out_sequence_last", want.seq_last, out_sequence_last);
  endtask

  // Inputs are taken before outputs so a same-edge result finds its expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      held_count = 0;
      group_size = GROUP_SIZE_RST;
      mismatches = 0;
    end else begin
      if (in_valid && !in_stall) take_element(in_value, in_end_of_sequence);
      if (out_valid && !out_stall) check_result();
      if (psel && penable && pwrite && pready && paddr == GROUP_SIZE_ADDR)
        group_size = pwdata[GS_W-1:0];
    end
    pending = expected_results.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the stream k-group reverser testbench: clock, reset, stimulus and verdict.
// Depends on skgr_pkg, stream_k_group_reverser and group_order_checker.
`timescale 1ns / 1ps

module testbench;
  import skgr_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 7;
  localparam int ITEMS_PER_PHASE = 32;
  localparam int SETTLE_CYCLES   = 24;
  localparam int CYCLE_LIMIT     = 200000;
  localparam logic [APB_ADDR_W-1:0] GROUP_SIZE_ADDR = APB_ADDR_W'(4 * int'(REG_GROUP_SIZE));

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_value;
  logic                     in_end_of_sequence;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_run_last;
  logic                     out_sequence_last;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0]    pwdata;
  logic [APB_DATA_W-1:0]    prdata;
  logic                     pready;

  int          mismatches;
  int          pending;
  int          cycle_count = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          stall_tick = 0;
  int          size_plan[10] = '{1, 16, 31, 0, 2, 3, 5, 7, 17, 4};

  always #CLK_HALF clk = ~clk;

  stream_k_group_reverser dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_value, .in_end_of_sequence,
    .out_valid, .out_stall, .out_value, .out_run_last, .out_sequence_last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  group_order_checker order_check (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_value, .in_end_of_sequence,
    .out_valid, .out_stall, .out_value, .out_run_last, .out_sequence_last,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .mismatches, .pending
  );

  // Hard stop
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stream_k_group_reverser regression: fail");
      $finish;
    end
  end

  // Receiver back-pressure: a mode picked at random, held for a random stretch
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(40, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_tick % 5) < 2;
    endcase
  end

  // Mostly random, with the corners of the value range mixed in
  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // One input transfer; returns at the accepting edge
  task automatic push_item(input logic signed [DATA_W-1:0] value, input logic eos);
    @(negedge clk);
    in_valid           <= 1'b1;
    in_value           <= value;
    in_end_of_sequence <= eos;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Sender bursts, with random gaps between them when gaps are on
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) hold_off($urandom_range(1, 6));
    end
    burst_left--;
  endtask

  // Stop sending until every expected result is out, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    hold_off(SETTLE_CYCLES);
  endtask

  task automatic write_group_size(input int gs);
    drain();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GROUP_SIZE_ADDR;
    pwdata  <= APB_DATA_W'(gs);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random sequences sized around the group size; a phase may end mid-group
  task automatic run_phase(input int gs);
    int k;
    int seq_left;
    write_group_size(gs);
    k = (gs == 0) ? 1 : ((gs > MAX_GROUP_DEF) ? MAX_GROUP_DEF : gs);
    gaps_on = ($urandom_range(0, 3) != 0);
    seq_left = 0;
    for (int sent = 0; sent < ITEMS_PER_PHASE; sent++) begin
      if (seq_left == 0) begin
        case ($urandom_range(0, 9))
          0:       seq_left = 1;
          1, 2:    seq_left = k * $urandom_range(1, 2);
          default: seq_left = $urandom_range(1, 2 * k + 1);
        endcase
      end
      push_item(random_value(), seq_left == 1);
      seq_left--;
      pace();
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_value           = '0;
    in_end_of_sequence = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Group size of one out of reset: every element is a run of its own
    push_item(32'h8000_0000, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b1);
    // Zero behaves as one
    write_group_size(0);
    push_item('1, 1'b1);
    // Full group ending the sequence, then a short tail kept in order
    write_group_size(3);
    push_item(1, 1'b0);
    push_item(2, 1'b0);
    push_item(3, 1'b1);
    push_item(32'h5555_5555, 1'b0);
    push_item(32'hAAAA_AAAA, 1'b1);
    // Group size lowered with elements buffered: everything held reverses at once
    write_group_size(4);
    push_item(10, 1'b0);
    push_item(11, 1'b0);
    push_item(12, 1'b0);
    write_group_size(2);
    push_item(13, 1'b0);
    // Oversized setting saturates to the buffer depth
    write_group_size(31);
    for (int i = 0; i < MAX_GROUP_DEF; i++) push_item(random_value(), i == MAX_GROUP_DEF - 1);

    size_plan[9] = $urandom_range(0, 31);
    foreach (size_plan[p]) run_phase(size_plan[p]);

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("stream_k_group_reverser regression: pass");
    end else begin
      $display("stream_k_group_reverser regression: fail");
    end
    $finish;
  end

endmodule
